[hw/rtl/tdtb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task delay timer bank package
// Field widths, command codes and fixed constants shared by the timer bank
// and its divide unit.
// ----------------------------------------------------------------------------
package tdtb_pkg;

    localparam int CMD_W    = 1;
    localparam int SLOT_W   = 5;
    localparam int DELAY_W  = 16;
    localparam int PERIOD_W = 10;
    localparam int COUNT_W  = 17;
    localparam int SEC_W    = 32;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int MS_PER_SECOND = 1000;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2);

    localparam logic [CMD_W-1:0] CMD_SET  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

endpackage

[hw/rtl/tdtb_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay divide unit
// Restoring divider that turns a delay in milliseconds into ticks, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdtb_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [tdtb_pkg::DELAY_W-1:0]    i_dividend,
    input  logic [tdtb_pkg::PERIOD_W-1:0]   i_divisor,
    output logic                            o_done,
    output logic [tdtb_pkg::DELAY_W-1:0]    o_quot
);
    import tdtb_pkg::*;

    localparam int CNT_W = $clog2(DELAY_W + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [PERIOD_W-1:0]   r_rem, n_rem;
    logic [DELAY_W-1:0]    r_quo, n_quo;
    logic [PERIOD_W-1:0]   r_dvs, n_dvs;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W-1:0]   diff;
    logic                  ge;

    assign trial = {r_rem, r_quo[DELAY_W-1]};
    // When the trial value reaches the divisor the difference is below the
    // divisor, so the low bits hold it exactly.
    assign diff  = trial[PERIOD_W-1:0] - r_dvs;
    assign ge    = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DELAY_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // The partial remainder always stays below the divisor.
            n_rem = ge ? diff : trial[PERIOD_W-1:0];
            n_quo = {r_quo[DELAY_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

[hw/rtl/task_delay_timer_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task delay timer bank
// Per-slot tick countdowns with wake reporting and a runtime seconds counter.
// ----------------------------------------------------------------------------
// One beat is taken at a time. A set command is accepted, then its delay is
// divided by the tick period in a bit-serial divide, then one write goes to
// the slot memory. A tick is accepted and adds its period to the
// millisecond accumulator, which then carries out one second per step
// (at most two); the walk then reads and rewrites each countdown in
// ascending order through the registered read port and the write port of
// the slot memory, and then the tick issues its closing result beat, all of
// which takes longer while the output stalls. Wake beats
// come out in ascending slot order; the last beat of each tick has o_last
// set, and a tick without expiries gives one beat with o_wake_valid low.
// Set commands give no output beat, and a set to a slot at or beyond
// NUM_SLOTS is dropped. A tick period of zero acts as one millisecond.
// Countdowns are cleared at reset through per-slot valid flags, so the block
// is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module task_delay_timer_bank #(
    parameter int NUM_SLOTS = tdtb_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [tdtb_pkg::PERIOD_W-1:0]   i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [tdtb_pkg::CMD_W-1:0]      i_command,
    input  logic [tdtb_pkg::SLOT_W-1:0]     i_task_slot,
    input  logic [tdtb_pkg::DELAY_W-1:0]    i_delay_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_wake_valid,
    output logic [tdtb_pkg::SLOT_W-1:0]     o_wake_task,
    output logic [tdtb_pkg::SEC_W-1:0]      o_runtime_seconds,
    output logic                            o_last
);
    import tdtb_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NW_W  = $clog2(MAX_RESULTS + 1);
    localparam int SUB_W = PERIOD_W + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_ACC   = 7'b0000100,
        S_RD    = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_FINAL = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [PERIOD_W-1:0]    r_period;
    logic [PERIOD_W-1:0]    eff_period;
    logic [SUB_W-1:0]       r_sub, n_sub;
    logic [SEC_W-1:0]       r_sec, n_sec;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_set_slot, n_set_slot;
    logic [NW_W-1:0]        r_nwake, n_nwake;
    logic                   r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]      r_pend_slot, n_pend_slot;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_wake, n_out_wake;
    logic [SLOT_W-1:0]      r_out_task, n_out_task;
    logic [SEC_W-1:0]       r_out_sec, n_out_sec;
    logic                   r_out_last, n_out_last;

    logic [COUNT_W-1:0]     r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_vbits;
    logic [COUNT_W-1:0]     r_rd_data;
    logic                   r_rd_vld;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;
    logic [COUNT_W-1:0]     mem_wd;

    logic                   div_start;
    logic                   div_done;
    logic [DELAY_W-1:0]     div_quot;

    logic                   out_free;
    logic [COUNT_W-1:0]     cnt;
    logic                   hit;
    logic                   adv;

    assign eff_period = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign out_free   = !r_out_valid || !i_out_stall;
    // A slot never written since reset reads as a zero countdown.
    assign cnt        = r_rd_vld ? r_rd_data : '0;
    assign hit        = (cnt == COUNT_W'(1)) && (r_nwake < NW_W'(MAX_RESULTS));

    tdtb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_delay_ms),
        .i_divisor  (eff_period),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state      = r_state;
        n_sub        = r_sub;
        n_sec        = r_sec;
        n_idx        = r_idx;
        n_set_slot   = r_set_slot;
        n_nwake      = r_nwake;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_out_valid  = r_out_valid;
        n_out_wake   = r_out_wake;
        n_out_task   = r_out_task;
        n_out_sec    = r_out_sec;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_wa       = r_idx;
        mem_wd       = '0;
        div_start    = 1'b0;
        adv          = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_TICK) begin
                        n_sub        = r_sub + SUB_W'(eff_period);
                        n_idx        = '0;
                        n_nwake      = '0;
                        n_pend_valid = 1'b0;
                        n_state      = S_ACC;
                    end else if (32'(i_task_slot) < NUM_SLOTS) begin
                        n_set_slot = IDX_W'(i_task_slot);
                        div_start  = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_set_slot;
                    mem_wd  = COUNT_W'(div_quot) + COUNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_ACC: begin
                if (r_sub >= SUB_W'(MS_PER_SECOND)) begin
                    n_sub = r_sub - SUB_W'(MS_PER_SECOND);
                    n_sec = r_sec + SEC_W'(1);
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (cnt != '0) begin
                    mem_we = 1'b1;
                    mem_wd = cnt - COUNT_W'(1);
                end
                // A wake is held back one step so the final one can carry o_last.
                if (hit) begin
                    n_nwake = r_nwake + NW_W'(1);
                    if (!r_pend_valid) begin
                        n_pend_valid = 1'b1;
                        n_pend_slot  = SLOT_W'(r_idx);
                        adv          = 1'b1;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_wake  = 1'b1;
                        n_out_task  = r_pend_slot;
                        n_out_sec   = r_sec;
                        n_out_last  = 1'b0;
                        n_pend_slot = SLOT_W'(r_idx);
                        adv         = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    adv = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_wake  = 1'b1;
                    n_out_task  = r_pend_slot;
                    n_out_sec   = r_sec;
                    n_out_last  = 1'b0;
                    n_pend_slot = SLOT_W'(r_idx);
                    adv         = 1'b1;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_wake  = r_pend_valid;
                    n_out_task  = r_pend_valid ? r_pend_slot : '0;
                    n_out_sec   = r_sec;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            if (r_idx == IDX_W'(NUM_SLOTS - 1)) begin
                n_state = S_FINAL;
            end else begin
                n_idx   = r_idx + IDX_W'(1);
                n_state = S_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_period     <= PERIOD_RESET;
            r_sub        <= '0;
            r_sec        <= '0;
            r_nwake      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            r_sub        <= n_sub;
            r_sec        <= n_sec;
            r_nwake      <= n_nwake;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
        end
        r_set_slot  <= n_set_slot;
        r_pend_slot <= n_pend_slot;
        r_out_wake  <= n_out_wake;
        r_out_task  <= n_out_task;
        r_out_sec   <= n_out_sec;
        r_out_last  <= n_out_last;
    end

    // Slot countdown memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (r_state == S_RD) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbits  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vbits[mem_wa] <= 1'b1;
            end
            if (r_state == S_RD) begin
                r_rd_vld <= r_vbits[r_idx];
            end
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_wake_valid      = r_out_wake;
    assign o_wake_task       = r_out_task;
    assign o_runtime_seconds = r_out_sec;
    assign o_last            = r_out_last;

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == CMD_TICK)
        |=> (r_state == S_ACC && r_nwake == '0 && !r_pend_valid))
        else $error("tick beat did not start the accumulator update");

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_sub < SUB_W'(MS_PER_SECOND)))
        else $error("millisecond accumulator not normalized before the walk");

    a_final_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && out_free)
        |=> (o_out_valid && o_last && r_state == S_IDLE))
        else $error("closing beat of a tick was not issued");

    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_pend_valid && r_out_valid))
        else $error("waiting on output without a held wake");

    a_wake_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nwake <= NW_W'(MAX_RESULTS))
        else $error("wake count exceeded the per-tick cap");

endmodule

[dv/task_delay_timer_bank_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task delay timer bank testbench
// Drives set and tick commands through the input channel and checks every
// wake beat against a cycle-free model of the countdown bank. A directed
// table comes first, then random phases, each under its own tick period,
// with bursty input traffic and output stalls.
// ----------------------------------------------------------------------------
module task_delay_timer_bank_test;
    import tdtb_pkg::*;

    typedef struct packed {
        logic               wake_valid;
        logic [SLOT_W-1:0]  wake_task;
        logic [SEC_W-1:0]   runtime_seconds;
        logic               last;
    } t_wake_beat;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] delay;
        logic               typed;
        t_wake_beat         want;
    } t_script_row;

    localparam t_wake_beat  QUIET_TICK   = '{1'b0, 5'd0, 32'd0, 1'b1};
    localparam t_wake_beat  BY_MODEL     = '0;
    localparam int          SCRIPT_LEN   = 18;
    localparam int          PHASE_ITEMS  = 42;
    localparam int          LONG_HOLD    = 400;
    localparam int          SETTLE_CYC   = 40;
    localparam int          DRAIN_CYC    = 100;

    // Slots touched cover every bit of the slot field; the delays cover every
    // bit of the delay field, zero and the largest value.
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{CMD_TICK, 5'd0,  16'd0,      1'b1, QUIET_TICK},
        '{CMD_SET,  5'd0,  16'd0,      1'b0, BY_MODEL},
        '{CMD_SET,  5'd31, 16'd1,      1'b0, BY_MODEL},
        '{CMD_TICK, 5'd0,  16'd0,      1'b0, BY_MODEL},
        '{CMD_TICK, 5'd31, 16'hffff,   1'b1, QUIET_TICK},
        '{CMD_SET,  5'd7,  16'hffff,   1'b0, BY_MODEL},
        '{CMD_SET,  5'd16, 16'd3,      1'b0, BY_MODEL},
        '{CMD_TICK, 5'd0,  16'd0,      1'b1, QUIET_TICK},
        '{CMD_TICK, 5'd0,  16'd0,      1'b1, '{1'b1, 5'd16, 32'd0, 1'b1}},
        '{CMD_SET,  5'd7,  16'd0,      1'b0, BY_MODEL},
        '{CMD_TICK, 5'd0,  16'd0,      1'b1, '{1'b1, 5'd7, 32'd0, 1'b1}},
        '{CMD_SET,  5'd21, 16'h5555,   1'b0, BY_MODEL},
        '{CMD_SET,  5'd10, 16'haaaa,   1'b0, BY_MODEL},
        '{CMD_SET,  5'd21, 16'd5,      1'b0, BY_MODEL},
        '{CMD_SET,  5'd10, 16'd5,      1'b0, BY_MODEL},
        '{CMD_TICK, 5'd0,  16'd0,      1'b1, QUIET_TICK},
        '{CMD_TICK, 5'd0,  16'd0,      1'b1, QUIET_TICK},
        '{CMD_TICK, 5'd0,  16'd0,      1'b0, BY_MODEL}
    };

    // A period of -1 stands for a random one.
    localparam int PHASE_PERIODS [7] = '{1000, 0, 1023, 1, -1, 2, -1};

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_cfg_wr_en    = 1'b0;
    logic [PERIOD_W-1:0]    i_cfg_wr_data  = '0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_stall;
    logic [CMD_W-1:0]       i_command      = CMD_SET;
    logic [SLOT_W-1:0]      i_task_slot    = '0;
    logic [DELAY_W-1:0]     i_delay_ms     = '0;
    logic                   o_out_valid;
    logic                   i_out_stall    = 1'b0;
    logic                   o_wake_valid;
    logic [SLOT_W-1:0]      o_wake_task;
    logic [SEC_W-1:0]       o_runtime_seconds;
    logic                   o_last;

    // Model of the bank.
    logic [COUNT_W-1:0]     countdown [NUM_SLOTS_DEF];
    logic [PERIOD_W-1:0]    period_ms;
    int                     subsec_ms;
    logic [SEC_W-1:0]       seconds;
    t_wake_beat             wake_beats_due [$];

    int                     mismatches  = 0;
    int                     stall_mode  = 1;
    bit                     idle_sender = 1'b1;
    int                     burst_left  = 0;
    int                     hold_ask    = 0;
    int                     hold_done   = 0;
    int                     hold_left   = 0;
    int                     rx_cycle    = 0;

    task_delay_timer_bank u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_task_slot       (i_task_slot),
        .i_delay_ms        (i_delay_ms),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_wake_valid      (o_wake_valid),
        .o_wake_task       (o_wake_task),
        .o_runtime_seconds (o_runtime_seconds),
        .o_last            (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL task_delay_timer_bank");
        $finish;
    end

    function automatic int eff_period();
        return (period_ms == '0) ? 1 : int'(period_ms);
    endfunction

    // Updates the bank model for one accepted command and, when asked, queues
    // the wake beats that the command should produce.
    task automatic apply_timer_command(input logic [CMD_W-1:0] cmd,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [DELAY_W-1:0] delay,
                                       input bit queue_beats);
        int woke [$];
        t_wake_beat beat;
        if (cmd == CMD_SET) begin
            countdown[slot] = COUNT_W'(int'(delay) / eff_period() + 1);
            return;
        end
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            if (countdown[i] != '0) begin
                countdown[i] = countdown[i] - 1'b1;
                if (countdown[i] == '0 && woke.size() < MAX_RESULTS)
                    woke.push_back(i);
            end
        end
        subsec_ms = subsec_ms + eff_period();
        while (subsec_ms >= MS_PER_SECOND) begin
            subsec_ms = subsec_ms - MS_PER_SECOND;
            seconds = seconds + 1'b1;
        end
        if (!queue_beats)
            return;
        if (woke.size() == 0) begin
            beat = '{1'b0, SLOT_W'(0), seconds, 1'b1};
            wake_beats_due.push_back(beat);
        end else begin
            foreach (woke[k]) begin
                beat = '{1'b1, SLOT_W'(woke[k]), seconds, k == woke.size() - 1};
                wake_beats_due.push_back(beat);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Offers one beat and returns at the edge where it is taken.
    task automatic send_beat(input logic [CMD_W-1:0] cmd,
                             input logic [SLOT_W-1:0] slot,
                             input logic [DELAY_W-1:0] delay);
        int gap;
        if (burst_left == 0) begin
            gap = idle_sender ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_task_slot <= slot;
        i_delay_ms  <= delay;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_and_predict(input logic [CMD_W-1:0] cmd,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic [DELAY_W-1:0] delay);
        send_beat(cmd, slot, delay);
        apply_timer_command(cmd, slot, delay, 1'b1);
    endtask

    // A set gives no beat, so the block may still be busy once the queue
    // empties; the settle time covers its divide.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (wake_beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic load_tick_period(input logic [PERIOD_W-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        period_ms = value;
    endtask

    // Receiver: checks each taken beat and picks the stall for the next cycle.
    always @(posedge i_clk) begin
        t_wake_beat want;
        logic stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (wake_beats_due.size() == 0) begin
                report_mismatch("beat with nothing due, task", o_wake_task, -1);
            end else begin
                want = wake_beats_due.pop_front();
                if (o_wake_valid !== want.wake_valid)
                    report_mismatch("wake_valid", o_wake_valid, want.wake_valid);
                if (o_wake_task !== want.wake_task)
                    report_mismatch("wake_task", o_wake_task, want.wake_task);
                if (o_runtime_seconds !== want.runtime_seconds)
                    report_mismatch("runtime_seconds", o_runtime_seconds,
                                    want.runtime_seconds);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (hold_ask != hold_done) begin
            hold_done = hold_ask;
            hold_left = LONG_HOLD;
            stall_next = 1'b1;
        end else begin
            case (stall_mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 2) == 0);
                2: stall_next = ((rx_cycle % 7) < 3);
                default: stall_next = ($urandom_range(0, 3) != 0);
            endcase
        end
        rx_cycle++;
        i_out_stall <= stall_next;
    end

    initial begin
        int sent;
        int pick;
        int eff;
        int group;
        int base;
        logic [DELAY_W-1:0] delay;
        logic [PERIOD_W-1:0] period;

        foreach (countdown[i]) countdown[i] = '0;
        period_ms = PERIOD_RESET;
        subsec_ms = 0;
        seconds   = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset tick period.
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            send_beat(SCRIPT[r].cmd, SCRIPT[r].slot, SCRIPT[r].delay);
            apply_timer_command(SCRIPT[r].cmd, SCRIPT[r].slot, SCRIPT[r].delay,
                                !SCRIPT[r].typed);
            if (SCRIPT[r].typed)
                wake_beats_due.push_back(SCRIPT[r].want);
        end

        for (int p = 0; p < 7; p++) begin
            period = (PHASE_PERIODS[p] < 0) ? PERIOD_W'($urandom_range(1, 1023))
                                            : PERIOD_W'(PHASE_PERIODS[p]);
            load_tick_period(period);
            stall_mode  = p % 4;
            idle_sender = (p % 3 != 2);
            eff = eff_period();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // One long output hold-off in the second phase, while the sender still leaves gaps.
                if (p == 1 && sent == 10)
                    hold_ask++;
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    send_and_predict(CMD_TICK, SLOT_W'($urandom()), DELAY_W'($urandom()));
                    sent++;
                end else if (pick < 86) begin
                    delay = DELAY_W'(eff * $urandom_range(0, 6) + $urandom_range(0, eff - 1));
                    send_and_predict(CMD_SET, SLOT_W'($urandom()), delay);
                    sent++;
                end else if (pick < 93) begin
                    // Several slots loaded alike expire on the same tick.
                    group = ($urandom_range(0, 3) == 0) ? NUM_SLOTS_DEF
                                                        : $urandom_range(2, 8);
                    base  = $urandom_range(0, NUM_SLOTS_DEF - 1);
                    delay = DELAY_W'(eff * $urandom_range(0, 3));
                    for (int j = 0; j < group; j++)
                        send_and_predict(CMD_SET, SLOT_W'((base + j) % NUM_SLOTS_DEF),
                                         delay);
                    sent += group;
                end else begin
                    send_and_predict(CMD_SET, SLOT_W'($urandom()), DELAY_W'($urandom()));
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (wake_beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS task_delay_timer_bank");
        else
            $display("FAIL task_delay_timer_bank");
        $finish;
    end

endmodule
